>>> rtl/core/vos_pkg.sv
// Package for the voxel occupancy set unit: widths, command codes, reset values.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package vos_pkg;
	localparam int TABLE_ENTRIES_DEF = 4096;
	localparam int AXIS_BITS_DEF = 21;
	localparam int LEAF_W = 20;
	localparam int COORD_W = 32;
	localparam int COUNT_W = 13;
	localparam logic [LEAF_W-1:0] LEAF_RESET = 20'd9830;
	localparam logic [63:0] HASH_MULT = 64'h9E3779B97F4A7C15;

	typedef enum logic [1:0] {
		FUNC_CLEAR  = 2'd0,
		FUNC_INSERT = 2'd1,
		FUNC_QUERY  = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	// result flags registered by the top level
	typedef struct packed {
		logic                occupied;
		logic                table_full;
		logic                out_of_range;
	} vos_flags_t;
endpackage
`default_nettype wire

>>> rtl/core/voxel_occupancy_set_unit.sv
// Top level of the voxel occupancy set: quantize, pack key, probe the hashed store.
// A request runs the divide, the hash and a read and check per probed slot, then the
// result strobe; an out-of-range request ends after the divide, and an unused command
// answers from idle without going busy. Clear sweeps every slot. One request runs at a
// time; busy stays high until the result strobe. Reset: a sweep clears the valid marks;
// busy is high meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module voxel_occupancy_set_unit #(
	parameter int AXIS_BITS = vos_pkg::AXIS_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [1:0]                      func,
	input  wire logic signed [31:0]              x_coord,
	input  wire logic signed [31:0]              y_coord,
	input  wire logic signed [31:0]              z_coord,
	input  wire logic                            voxel_pitch_we,
	input  wire logic [vos_pkg::LEAF_W-1:0]      voxel_pitch,
	output logic                                 result_valid,
	output logic                                 occupied,
	output logic [vos_pkg::COUNT_W-1:0]          voxel_count,
	output logic                                 table_full,
	output logic                                 out_of_range
);
	localparam int W = vos_pkg::COORD_W;
	localparam int KEY_W = 3 * AXIS_BITS;
	localparam logic [W-1:0] HALF = W'(1) << (AXIS_BITS - 1);

	typedef enum logic [2:0] {S_BOOT, S_IDLE, S_DIV, S_PROBE, S_CLEAR} state_t;

	state_t                       st_q;
	logic [vos_pkg::LEAF_W-1:0]   leaf_q;
	vos_pkg::func_t               func_q;
	logic [vos_pkg::COUNT_W-1:0]  count_q;
	logic                         div_start, div_done, pr_start, pr_clear;
	logic                         pr_done, pr_found, pr_full, pr_added;
	logic [3*W-1:0]               quos;
	logic [W-1:0]                 idx [3];
	logic                         oor;
	logic [KEY_W-1:0]             key;
	vos_pkg::vos_flags_t          flags;

	// hold the leaf size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			leaf_q <= vos_pkg::LEAF_RESET;
		else if (voxel_pitch_we)
			leaf_q <= voxel_pitch;
	end

	assign div_start = (st_q == S_IDLE) && start &&
		(func == vos_pkg::FUNC_INSERT || func == vos_pkg::FUNC_QUERY);

	vos_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .divisor(leaf_q),
		.dividends({z_coord, y_coord, x_coord}), .done(div_done), .quotients(quos)
	);

	// offset indices, range check and key packing
	always_comb begin
		oor = 1'b0;
		for (int a = 0; a < 3; a++) begin
			idx[a] = quos[a*W +: W] + HALF;
			if (idx[a][W-1] || (idx[a] >> AXIS_BITS) != '0)
				oor = 1'b1;
		end
		key = {idx[0][AXIS_BITS-1:0], idx[1][AXIS_BITS-1:0], idx[2][AXIS_BITS-1:0]};
	end

	assign pr_start = (st_q == S_DIV) && div_done && !oor;
	assign pr_clear = (st_q == S_IDLE) && start && (func == vos_pkg::FUNC_CLEAR);

	vos_probe #(.KEY_W(KEY_W)) u_probe (
		.clk(clk), .arst_n(arst_n), .start(pr_start),
		.is_insert(func_q == vos_pkg::FUNC_INSERT), .do_clear(pr_clear), .key(key),
		.done(pr_done), .found(pr_found), .full(pr_full), .added(pr_added)
	);

	assign busy = (st_q != S_IDLE);
	assign occupied = flags.occupied;
	assign table_full = flags.table_full;
	assign out_of_range = flags.out_of_range;
	assign voxel_count = count_q;

	// advance the command sequencer and register the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_BOOT;
			count_q <= '0;
			result_valid <= 1'b0;
			flags <= '0;
			func_q <= vos_pkg::FUNC_NONE;
		end else begin
			result_valid <= 1'b0;
			case (st_q)
				S_BOOT: if (pr_done) st_q <= S_IDLE;
				S_IDLE: begin
					if (start) begin
						func_q <= vos_pkg::func_t'(func);
						if (pr_clear) begin
							st_q <= S_CLEAR;
						end else if (div_start) begin
							st_q <= S_DIV;
						end else begin
							flags <= '0;
							result_valid <= 1'b1;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (oor) begin
							flags <= '{occupied: 1'b0, table_full: 1'b0, out_of_range: 1'b1};
							result_valid <= 1'b1;
							st_q <= S_IDLE;
						end else begin
							st_q <= S_PROBE;
						end
					end
				end
				S_PROBE: begin
					if (pr_done) begin
						flags <= '{occupied: pr_found && func_q == vos_pkg::FUNC_QUERY,
							table_full: pr_full, out_of_range: 1'b0};
						if (pr_added)
							count_q <= count_q + vos_pkg::COUNT_W'(1);
						result_valid <= 1'b1;
						st_q <= S_IDLE;
					end
				end
				S_CLEAR: begin
					if (pr_done) begin
						count_q <= '0;
						flags <= '0;
						result_valid <= 1'b1;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// only one flag kind per result
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $countones({occupied, table_full, out_of_range}) <= 1)
		else $error("more than one result flag");
	// a result ends the command; the block is ready afterwards
	a_ready_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("busy after result");
	// the count moves only with a result
	a_count_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> $stable(voxel_count) || $past(st_q) == S_BOOT)
		else $error("count changed without result");
endmodule
`default_nettype wire

>>> rtl/core/vos_divider.sv
// Sequential floor divider: one quotient bit per cycle, three axes in parallel lanes.
// Depends on vos_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
module vos_divider (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [vos_pkg::LEAF_W-1:0]      divisor,
	input  wire logic [3*vos_pkg::COORD_W-1:0]   dividends,
	output logic                                 done,
	output logic [3*vos_pkg::COORD_W-1:0]        quotients
);
	localparam int W = vos_pkg::COORD_W;
	localparam int CW = $clog2(W+1);
	localparam int LEAF_W_EXT = vos_pkg::LEAF_W;

	logic [CW-1:0]  cnt_q;
	logic           run_q;
	logic [W-1:0]   mag_q [3];
	logic [W-1:0]   quo_q [3];
	logic [W:0]     rem_q [3];
	logic           neg_q [3];
	logic [LEAF_W_EXT-1:0] dv_q;

	// step one restoring-division bit per lane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
			dv_q <= LEAF_W_EXT'(1);
			for (int a = 0; a < 3; a++) begin
				neg_q[a] <= 1'b0;
				mag_q[a] <= '0;
				rem_q[a] <= '0;
				quo_q[a] <= '0;
			end
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W);
				dv_q <= (divisor == '0) ? LEAF_W_EXT'(1) : divisor;
				for (int a = 0; a < 3; a++) begin
					neg_q[a] <= dividends[a*W+W-1];
					mag_q[a] <= dividends[a*W+W-1] ? (~dividends[a*W +: W] + W'(1))
						: dividends[a*W +: W];
					rem_q[a] <= '0;
					quo_q[a] <= '0;
				end
			end else if (run_q) begin
				for (int a = 0; a < 3; a++) begin
					logic [W:0] t;
					t = {rem_q[a][W-1:0], mag_q[a][W-1]};
					mag_q[a] <= {mag_q[a][W-2:0], 1'b0};
					if (t >= (W+1)'(dv_q)) begin
						rem_q[a] <= t - (W+1)'(dv_q);
						quo_q[a] <= {quo_q[a][W-2:0], 1'b1};
					end else begin
						rem_q[a] <= t;
						quo_q[a] <= {quo_q[a][W-2:0], 1'b0};
					end
				end
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// apply sign with floor: negative nonexact rounds down
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			if (neg_q[a])
				quotients[a*W +: W] = ~quo_q[a] + W'(1) - W'(rem_q[a] != '0);
			else
				quotients[a*W +: W] = quo_q[a];
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/vos_probe.sv
// Hash probe engine: key memory, valid marks, linear probing, read-modify-write.
// Depends on vos_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vos_probe #(
	parameter int KEY_W = 63
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic                is_insert,
	input  wire logic                do_clear,
	input  wire logic [KEY_W-1:0]    key,
	output logic                     done,
	output logic                     found,
	output logic                     full,
	output logic                     added
);
	localparam int TABLE_ENTRIES = vos_pkg::TABLE_ENTRIES_DEF;
	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int NW = AW + 1;

	typedef enum logic [3:0] {
		P_IDLE, P_MUL_LL, P_MUL_LH, P_MUL_HL, P_HASH, P_HOME, P_READ, P_CHECK, P_CLR
	} pstate_t;

	logic [KEY_W-1:0] key_mem [TABLE_ENTRIES];
	logic [KEY_W-1:0] rd_key_q;
	logic             vmem [TABLE_ENTRIES];
	logic             rd_valid_q;
	logic [AW-1:0]    slot_q;
	logic [NW-1:0]    tries_q;
	logic [63:0]      hash_q;
	logic [KEY_W-1:0] key_q;
	logic             ins_q;
	pstate_t          st_q;
	logic [63:0]      key_ext;
	logic [31:0]      mul_a, mul_b;
	logic [63:0]      prod;

	// memory port: read current slot, write on insert
	always_ff @(posedge clk) begin
		rd_key_q <= key_mem[slot_q];
		if (st_q == P_CHECK && ins_q && !rd_valid_q)
			key_mem[slot_q] <= key_q;
	end

	// valid marks: registered read, cleared by a sweep
	always_ff @(posedge clk) begin
		rd_valid_q <= vmem[slot_q];
		if (st_q == P_CLR)
			vmem[slot_q] <= 1'b0;
		else if (st_q == P_CHECK && ins_q && !rd_valid_q)
			vmem[slot_q] <= 1'b1;
	end

	// select the 32-bit operand halves for the current hash step's partial product
	assign key_ext = 64'(key_q);
	always_comb begin
		case (st_q)
			P_MUL_LH: begin
				mul_a = key_ext[31:0];
				mul_b = vos_pkg::HASH_MULT[63:32];
			end
			P_MUL_HL: begin
				mul_a = key_ext[63:32];
				mul_b = vos_pkg::HASH_MULT[31:0];
			end
			default: begin
				mul_a = key_ext[31:0];
				mul_b = vos_pkg::HASH_MULT[31:0];
			end
		endcase
	end
	assign prod = {32'b0, mul_a} * {32'b0, mul_b};

	logic [63:0] hmix;
	assign hmix = hash_q ^ (hash_q >> 29);

	// sequence hash, probe and clear sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= P_CLR;
			slot_q <= '0;
			done <= 1'b0;
			found <= 1'b0;
			full <= 1'b0;
			added <= 1'b0;
			tries_q <= '0;
			hash_q <= '0;
			key_q <= '0;
			ins_q <= 1'b0;
		end else begin
			done <= 1'b0;
			case (st_q)
				P_IDLE: begin
					if (do_clear) begin
						st_q <= P_CLR;
						slot_q <= '0;
					end else if (start) begin
						key_q <= key;
						ins_q <= is_insert;
						st_q <= P_MUL_LL;
					end
				end
				// build the low 64 bits of key times the hash constant
				P_MUL_LL: begin
					hash_q <= prod;
					st_q <= P_MUL_LH;
				end
				P_MUL_LH: begin
					hash_q <= hash_q + {prod[31:0], 32'b0};
					st_q <= P_MUL_HL;
				end
				P_MUL_HL: begin
					hash_q <= hash_q + {prod[31:0], 32'b0};
					st_q <= P_HASH;
				end
				P_HASH: begin
					slot_q <= hmix[AW-1:0];
					tries_q <= '0;
					st_q <= P_HOME;
				end
				P_HOME: st_q <= P_READ;
				P_READ: st_q <= P_CHECK;
				P_CHECK: begin
					found <= 1'b0;
					full <= 1'b0;
					added <= 1'b0;
					if (!rd_valid_q) begin
						added <= ins_q;
						done <= 1'b1;
						st_q <= P_IDLE;
					end else if (rd_key_q == key_q) begin
						found <= 1'b1;
						done <= 1'b1;
						st_q <= P_IDLE;
					end else if (tries_q == NW'(TABLE_ENTRIES - 1)) begin
						full <= ins_q;
						done <= 1'b1;
						st_q <= P_IDLE;
					end else begin
						tries_q <= tries_q + NW'(1);
						slot_q <= slot_q + AW'(1);
						st_q <= P_HOME;
					end
				end
				P_CLR: begin
					slot_q <= slot_q + AW'(1);
					if (slot_q == AW'(TABLE_ENTRIES - 1)) begin
						st_q <= P_IDLE;
						done <= 1'b1;
					end
				end
				default: st_q <= P_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> dv/vos_checker.sv
// Checker for the voxel occupancy set unit: watches requests, predicts each result, compares.
// Depends on vos_pkg for widths and command codes.
`timescale 1ns / 1ps
`default_nettype none
module vos_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic                        busy,
	input  wire logic [1:0]                  func,
	input  wire logic signed [31:0]          x_coord,
	input  wire logic signed [31:0]          y_coord,
	input  wire logic signed [31:0]          z_coord,
	input  wire logic                        voxel_pitch_we,
	input  wire logic [vos_pkg::LEAF_W-1:0]  voxel_pitch,
	input  wire logic                        result_valid,
	input  wire logic                        occupied,
	input  wire logic [vos_pkg::COUNT_W-1:0] voxel_count,
	input  wire logic                        table_full,
	input  wire logic                        out_of_range,
	output int                               fail_count,
	output int                               pending_count
);
	import vos_pkg::*;

	localparam int SLOTS = TABLE_ENTRIES_DEF;
	localparam int AB = AXIS_BITS_DEF;

	typedef struct packed {
		logic               occ;
		logic [COUNT_W-1:0] cnt;
		logic               full;
		logic               oor;
	} voxel_result_t;

	logic [62:0]        keys [SLOTS];
	bit                 marks [SLOTS];
	int unsigned        n_voxels;
	logic [LEAF_W-1:0]  leaf_reg;
	voxel_result_t      expected_results [$];

	assign pending_count = expected_results.size();

	// floor of coordinate over leaf, plus half the axis range
	function automatic longint quantize(input logic signed [31:0] c, input longint lf);
		longint cv, q;
		cv = c;
		q = cv / lf;
		if ((cv % lf) != 0 && cv < 0)
			q = q - 1;
		return q + (longint'(1) << (AB - 1));
	endfunction

	function automatic int hash_home(input logic [62:0] k);
		logic [63:0] h;
		h = {1'b0, k} * HASH_MULT;
		h = h ^ (h >> 29);
		return int'(h % SLOTS);
	endfunction

	function automatic voxel_result_t predict_voxel(input logic [1:0] f,
			input logic signed [31:0] xc, input logic signed [31:0] yc,
			input logic signed [31:0] zc);
		voxel_result_t r;
		longint lf, ix, iy, iz, lim;
		logic [62:0] k;
		int s, n, free_slot;
		bit hit;
		r = '0;
		if (f == FUNC_CLEAR) begin
			foreach (marks[i]) marks[i] = 0;
			n_voxels = 0;
		end else if (f == FUNC_INSERT || f == FUNC_QUERY) begin
			lf = (leaf_reg == 0) ? 1 : longint'(leaf_reg);
			lim = longint'(1) << AB;
			ix = quantize(xc, lf);
			iy = quantize(yc, lf);
			iz = quantize(zc, lf);
			if (ix < 0 || ix >= lim || iy < 0 || iy >= lim || iz < 0 || iz >= lim) begin
				r.oor = 1;
			end else begin
				k = {ix[AB-1:0], iy[AB-1:0], iz[AB-1:0]};
				s = hash_home(k);
				hit = 0;
				free_slot = -1;
				for (n = 0; n < SLOTS; n++) begin
					if (!marks[s]) begin
						free_slot = s;
						break;
					end
					if (keys[s] == k) begin
						hit = 1;
						break;
					end
					s = (s + 1) % SLOTS;
				end
				if (f == FUNC_QUERY) begin
					r.occ = hit;
				end else if (!hit) begin
					if (free_slot < 0) begin
						r.full = 1;
					end else begin
						keys[free_slot] = k;
						marks[free_slot] = 1;
						n_voxels++;
					end
				end
			end
		end
		r.cnt = n_voxels[COUNT_W-1:0];
		return r;
	endfunction

	// track config, predict on accepted requests, compare on strobes
	always @(posedge clk or negedge arst_n) begin
		voxel_result_t got, want;
		if (!arst_n) begin
			foreach (marks[i]) marks[i] = 0;
			n_voxels = 0;
			leaf_reg = LEAF_RESET;
			expected_results.delete();
			fail_count = 0;
		end else begin
			if (result_valid) begin
				got = '{occupied, voxel_count, table_full, out_of_range};
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: %p", got);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %p actual %p", want, got);
					end
				end
			end
			if (start && !busy)
				expected_results.push_back(predict_voxel(func, x_coord, y_coord, z_coord));
			if (voxel_pitch_we)
				leaf_reg = voxel_pitch;
		end
	end
endmodule
`default_nettype wire

>>> dv/tb_top.sv
// Testbench top for the voxel occupancy set unit: clock, reset, request stimulus, verdict.
// Depends on vos_pkg, voxel_occupancy_set_unit and vos_checker.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import vos_pkg::*;

	localparam int STALL_LIMIT = 60000;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic [1:0] func = FUNC_CLEAR;
	logic signed [31:0] x_coord = 0, y_coord = 0, z_coord = 0;
	logic voxel_pitch_we = 0;
	logic [LEAF_W-1:0] voxel_pitch = LEAF_RESET;
	logic busy, result_valid, occupied, table_full, out_of_range;
	logic [COUNT_W-1:0] voxel_count;
	int fail_count, pending_count;
	int idle_cycles;
	bit calm;

	always #4 clk = ~clk;

	voxel_occupancy_set_unit u_top (.*);

	vos_checker u_chk (.*);

	// watchdog: count cycles with no accepted request, result or leaf write
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || voxel_pitch_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("voxel_occupancy_set_unit regression: fail");
			$finish;
		end
	end

	// hold the request until accepted; start stays high between requests unless a random gap drops it
	task automatic send_point(input logic [1:0] f, input logic [31:0] xc,
			input logic [31:0] yc, input logic [31:0] zc);
		if (!calm && $urandom_range(99) < 23) begin
			start <= 0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		start <= 1;
		func <= f;
		x_coord <= xc;
		y_coord <= yc;
		z_coord <= zc;
		do @(posedge clk); while (busy);
	endtask

	task automatic write_leaf(input logic [LEAF_W-1:0] v);
		start <= 0;
		wait (pending_count == 0);
		repeat (40) @(posedge clk);
		voxel_pitch_we <= 1;
		voxel_pitch <= v;
		@(posedge clk);
		voxel_pitch_we <= 0;
	endtask

	// mostly near-origin points so voxels collide and repeat; sometimes any value
	function automatic logic [31:0] rand_coord(input int spread);
		if ($urandom_range(9) == 0)
			return $urandom;
		return $signed($urandom_range(2 * spread)) - spread;
	endfunction

	task automatic random_phase(input int n, input int spread);
		logic [1:0] f;
		int p;
		for (int i = 0; i < n; i++) begin
			calm = (i % 300) > 220;
			p = $urandom_range(99);
			f = p < 2 ? FUNC_CLEAR : p < 55 ? FUNC_INSERT : p < 97 ? FUNC_QUERY : FUNC_NONE;
			send_point(f, rand_coord(spread), rand_coord(spread), rand_coord(spread));
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes, every command, range edges, duplicates
		send_point(FUNC_QUERY, 0, 0, 0);
		send_point(FUNC_INSERT, 0, 0, 0);
		send_point(FUNC_INSERT, 0, 0, 0);
		send_point(FUNC_QUERY, 0, 0, 0);
		send_point(FUNC_INSERT, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
		send_point(FUNC_QUERY, 32'h80000000, 32'h7FFFFFFF, 1);
		send_point(FUNC_NONE, 32'hFFFFFFFF, 0, 0);
		send_point(FUNC_INSERT, -1, -1, -1);
		send_point(FUNC_QUERY, -9830, -1, -9831);
		send_point(FUNC_CLEAR, 0, 0, 0);
		send_point(FUNC_QUERY, 0, 0, 0);
		write_leaf(0);
		send_point(FUNC_INSERT, (1 << 20) - 1, -(1 << 20), 0);
		send_point(FUNC_INSERT, 1 << 20, 0, 0);
		send_point(FUNC_QUERY, -(1 << 20) - 1, 0, 0);
		send_point(FUNC_QUERY, (1 << 20) - 1, -(1 << 20), 0);
		write_leaf(20'hFFFFF);
		send_point(FUNC_INSERT, 32'h7FFFFFFF, 32'h80000000, 5);
		send_point(FUNC_QUERY, 32'h7FFFFFFF, 32'h80000000, 5);
		write_leaf(1);
		random_phase(300, 4000);
		write_leaf(LEAF_RESET);
		random_phase(350, 200000);
		write_leaf(20'hFFFFF);
		random_phase(250, 50000000);
		write_leaf(LEAF_W'($urandom_range(20'hFFFFF, 1)));
		random_phase(300, 500000);
		write_leaf(1);
		random_phase(330, 100);
		start <= 0;
		wait (pending_count == 0);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("voxel_occupancy_set_unit regression: pass");
		else
			$display("voxel_occupancy_set_unit regression: fail");
		$finish;
	end
endmodule
`default_nettype wire
